// File: rtl/core/stir_pkg.sv
package stir_pkg;

	localparam int CNT_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [ST_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [ST_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

	localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic              req_type;
		logic signed [31:0] item_value;
	} stir_in_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] member_total;
	} stir_out_t;

	typedef struct packed {
		logic            load;
		logic            idx_clr;
		logic            idx_inc;
		logic            rd_en;
		logic            rd_last;
		logic            wr_add;
		logic            wr_move;
		logic            out_load;
		logic [ST_W-1:0] out_status;
	} stir_cmd_t;

	typedef struct packed {
		logic is_remove;
		logic match;
		logic idx_last;
		logic count_zero;
		logic full;
		logic out_free;
	} stir_stat_t;

endpackage

// File: rtl/core/stir_ctrl.sv
module stir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  stir_pkg::stir_stat_t stat,
	output stir_pkg::stir_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_MISS,
		S_RDLAST,
		S_MOVE,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [stir_pkg::ST_W-1:0]       res_q;
	logic                            accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= stir_pkg::ST_ADDED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= stat.count_zero ? S_MISS : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (stat.match) begin
						if (stat.is_remove) begin
							state_q <= S_RDLAST;
						end else begin
							res_q   <= stir_pkg::ST_PRESENT;
							state_q <= S_DONE;
						end
					end else if (stat.idx_last) begin
						state_q <= S_MISS;
					end else begin
						state_q <= S_RD;
					end
				end
				S_MISS: begin
					if (stat.is_remove) begin
						res_q <= stir_pkg::ST_NOT_FOUND;
					end else if (stat.full) begin
						res_q <= stir_pkg::ST_FULL;
					end else begin
						res_q <= stir_pkg::ST_ADDED;
					end
					state_q <= S_DONE;
				end
				S_RDLAST: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					res_q   <= stir_pkg::ST_REMOVED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.out_status = res_q;
		cmd.load       = accept;
		cmd.idx_clr    = accept;
		case (state_q)
			S_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_CMP: begin
				cmd.idx_inc = !stat.match && !stat.idx_last;
			end
			S_MISS: begin
				cmd.wr_add = !stat.is_remove && !stat.full;
			end
			S_RDLAST: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_last = 1'b1;
			end
			S_MOVE: begin
				cmd.wr_move = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/core/stir_dp.sv
module stir_dp #(
	parameter int SET_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  stir_pkg::stir_in_t              in_data,
	input  logic                            cfg_valid,
	input  logic [stir_pkg::CNT_W-1:0]      cfg_data,
	input  logic                            out_stall,
	output logic                            out_valid,
	output stir_pkg::stir_out_t             out_data,
	input  stir_pkg::stir_cmd_t             cmd,
	output stir_pkg::stir_stat_t            stat
);

	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int IW = (AW > stir_pkg::CNT_W) ? AW : stir_pkg::CNT_W;

	logic [stir_pkg::VAL_W-1:0]  mem [SET_DEPTH];
	logic [stir_pkg::VAL_W-1:0]  rdata_q;
	logic [stir_pkg::VAL_W-1:0]  value_q;
	logic                        op_q;
	logic [stir_pkg::CNT_W-1:0]  count_q;
	logic [stir_pkg::CNT_W-1:0]  cap_q;
	logic [stir_pkg::CNT_W-1:0]  idx_q;
	logic                        out_valid_q;
	stir_pkg::stir_out_t         out_q;

	logic [stir_pkg::CNT_W-1:0]  last_idx;
	logic [IW-1:0]               rd_wide;
	logic [IW-1:0]               wr_wide;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;
	logic                        wr_en;
	logic [stir_pkg::VAL_W-1:0]  wr_data;

	assign last_idx = count_q - 7'd1;
	assign rd_wide  = cmd.rd_last ? IW'(last_idx) : IW'(idx_q);
	assign wr_wide  = cmd.wr_add ? IW'(count_q) : IW'(idx_q);
	assign rd_addr  = rd_wide[AW-1:0];
	assign wr_addr  = wr_wide[AW-1:0];
	assign wr_en    = cmd.wr_add || cmd.wr_move;
	assign wr_data  = cmd.wr_add ? value_q : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.load) begin
			op_q    <= in_data.req_type;
			value_q <= in_data.item_value;
		end
		if (cmd.out_load) begin
			out_q.status       <= cmd.out_status;
			out_q.member_total <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= stir_pkg::CAP_RESET;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 7'd1;
			end
			if (cmd.wr_add) begin
				count_q <= count_q + 7'd1;
			end else if (cmd.wr_move) begin
				count_q <= last_idx;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.is_remove  = (op_q == stir_pkg::REQ_REMOVE);
	assign stat.match      = (rdata_q == value_q);
	assign stat.idx_last   = ((8'(idx_q) + 8'd1) == 8'(count_q));
	assign stat.count_zero = (count_q == '0);
	assign stat.full       = (11'(count_q) >= 11'(cap_q)) || (11'(count_q) >= 11'(SET_DEPTH));
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/set_table_insert_remove_core.sv
// Channel   Handshake            Beat
// in        in_valid / in_stall   in_data: req_type, item_value
// out       out_valid / out_stall out_data: status, member_total
// cfg       cfg_valid / cfg_ready cfg_data: capacity_limit
//
// A request is taken only in idle. The live slots are read one at a time through the
// registered read port, a read state then a compare state per slot, up to a hit or
// the last slot; a remove that hits moves the last slot into the hit one. The next request
// is taken when its beat is loaded. Reset clears the count and restores the capacity to 64.
// A finished beat waits in the output register while the next request runs; the one after
// it holds the controller, and so the input, until that register drains.
module set_table_insert_remove_core #(
	parameter int SET_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  stir_pkg::stir_in_t          in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output stir_pkg::stir_out_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [stir_pkg::CNT_W-1:0]  cfg_data
);

	stir_pkg::stir_cmd_t  cmd;
	stir_pkg::stir_stat_t stat;

	assign cfg_ready = 1'b1;

	stir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	stir_dp #(
		.SET_DEPTH (SET_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// File: tb/sv/tb_set_table_insert_remove_core.sv
`timescale 1ns / 1ps

import stir_pkg::*;

localparam int TABLE_DEPTH = 64;

// Mirrors the live set and queues the outcome each accepted request beat should produce.
class membership_predictor;
	logic [VAL_W-1:0] slots[TABLE_DEPTH];
	int live_count;
	logic [CNT_W-1:0] capacity;
	stir_out_t pending_outcomes[$];
	int mismatches;

	function new();
		live_count = 0;
		capacity = CAP_RESET;
		mismatches = 0;
	endfunction

	function void set_capacity(input logic [CNT_W-1:0] cap);
		capacity = cap;
	endfunction

	function void note_request(input stir_in_t beat);
		int slot;
		int limit;
		stir_out_t outcome;
		slot = live_count;
		for (int i = 0; i < live_count; i++)
			if (slot == live_count && slots[i] == beat.item_value)
				slot = i;
		limit = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
		if (beat.req_type == REQ_INSERT) begin
			if (slot < live_count)
				outcome.status = ST_PRESENT;
			else if (live_count >= limit)
				outcome.status = ST_FULL;
			else begin
				slots[live_count] = beat.item_value;
				live_count++;
				outcome.status = ST_ADDED;
			end
		end else if (slot < live_count) begin
			slots[slot] = slots[live_count - 1];
			live_count--;
			outcome.status = ST_REMOVED;
		end else
			outcome.status = ST_NOT_FOUND;
		outcome.member_total = CNT_W'(live_count);
		pending_outcomes.push_back(outcome);
	endfunction

	function void check_outcome(input stir_out_t got);
		stir_out_t want;
		if (pending_outcomes.size() == 0) begin
			mismatches++;
			$display("%0t: result with nothing expected: status %0d, total %0d",
				$time, got.status, got.member_total);
			return;
		end
		want = pending_outcomes.pop_front();
		if (got.status !== want.status) begin
			mismatches++;
			$display("%0t: status mismatch: expected %0d, actual %0d",
				$time, want.status, got.status);
		end
		if (got.member_total !== want.member_total) begin
			mismatches++;
			$display("%0t: member_total mismatch: expected %0d, actual %0d",
				$time, want.member_total, got.member_total);
		end
	endfunction
endclass

module tb_set_table_insert_remove_core;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	stir_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	stir_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	logic steady = 1'b0;
	logic hold_request = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	membership_predictor board;

	set_table_insert_remove_core #(
		.SET_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_outcome(out_data);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else
			out_stall <= !steady && ($urandom_range(99) < 21);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL set_table_insert_remove_core");
			$finish;
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		logic [VAL_W-1:0] v;
		r = $urandom_range(99);
		if (r < 45 && board.live_count > 0)
			v = board.slots[$urandom_range(board.live_count - 1)];
		else if (r < 65)
			v = 32'($urandom_range(30)) - 32'd15;
		else if (r < 72) begin
			case ($urandom_range(3))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'h0000_0000;
				default: v = 32'hffff_ffff;
			endcase
		end else
			v = $urandom;
		return v;
	endfunction

	task automatic send_request(input logic op, input logic [VAL_W-1:0] v);
		stir_in_t beat;
		int gap;
		beat.req_type = op;
		beat.item_value = v;
		if (!steady && $urandom_range(99) < 21) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		board.note_request(beat);
	endtask

	task automatic random_burst(input int n, input int insert_pct);
		repeat (n)
			send_request(($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
				pick_value());
	endtask

	task automatic drain_outcomes();
		in_valid <= 1'b0;
		while (board.pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		drain_outcomes();
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_capacity(cap);
	endtask

	initial begin
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(CAP_RESET);
		send_request(REQ_INSERT, 32'h8000_0000);
		send_request(REQ_INSERT, 32'h7fff_ffff);
		send_request(REQ_INSERT, 32'h0000_0000);
		send_request(REQ_INSERT, 32'hffff_ffff);
		send_request(REQ_INSERT, 32'h7fff_ffff);
		send_request(REQ_REMOVE, 32'd5);
		send_request(REQ_REMOVE, 32'h8000_0000);
		send_request(REQ_REMOVE, 32'hffff_ffff);
		send_request(REQ_REMOVE, 32'h0000_0000);
		send_request(REQ_REMOVE, 32'h7fff_ffff);
		send_request(REQ_REMOVE, 32'h0000_0000);

		write_capacity(7'd0);
		send_request(REQ_INSERT, 32'd7);
		send_request(REQ_REMOVE, 32'd7);

		write_capacity(7'd1);
		send_request(REQ_INSERT, 32'd7);
		send_request(REQ_INSERT, 32'd8);
		send_request(REQ_INSERT, 32'd7);

		write_capacity(7'd127);
		send_request(REQ_INSERT, 32'd8);
		send_request(REQ_INSERT, 32'd9);

		// The capacity drops below the live count; nothing is evicted.
		write_capacity(7'd1);
		send_request(REQ_INSERT, 32'd10);
		send_request(REQ_INSERT, 32'd9);
		send_request(REQ_REMOVE, 32'd7);
		send_request(REQ_INSERT, 32'd11);

		write_capacity(7'd127);
		random_burst(400, 75);
		hold_request <= 1'b1;
		random_burst(150, 50);
		drain_outcomes();

		write_capacity(7'd100);
		random_burst(300, 35);
		write_capacity(7'd0);
		random_burst(60, 50);
		write_capacity(7'd5);
		random_burst(200, 50);

		write_capacity(7'd64);
		steady <= 1'b1;
		random_burst(300, 70);
		steady <= 1'b0;

		write_capacity(7'd10);
		random_burst(200, 45);
		write_capacity(CNT_W'($urandom_range(127)));
		random_burst(200, 55);
		write_capacity(7'd64);
		random_burst(200, 50);

		drain_outcomes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending_outcomes.size() == 0)
			$display("PASS set_table_insert_remove_core");
		else
			$display("FAIL set_table_insert_remove_core");
		$finish;
	end
endmodule

// File: sim.f
rtl/core/stir_pkg.sv
rtl/core/stir_ctrl.sv
rtl/core/stir_dp.sv
rtl/core/set_table_insert_remove_core.sv
tb/sv/tb_set_table_insert_remove_core.sv
